[sv/plc_pkg.sv]
// Shared types, codes and sizes for the positional list engine.
package plc_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 8;
	localparam int CNT_W     = 5;
	localparam int CMD_W     = 2;
	localparam int ST_W      = 2;
	// Width wide enough to compare a position against the fill plus one.
	localparam int CMP_W     = 9;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

	typedef enum logic [2:0] {
		OP_HOLD  = 3'd0,
		OP_LEFT  = 3'd1,
		OP_RIGHT = 3'd2,
		OP_LOAD  = 3'd3,
		OP_WRAP  = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RESP = 3'b010,
		S_DUMP = 3'b100
	} state_t;

endpackage

[sv/plc_cell.sv]
// One storage cell of the list chain, taking data from either neighbour, the load value or the head cell.
module plc_cell
	import plc_pkg::*;
(
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	input  logic [DATA_W-1:0] wrap,
	input  logic [DATA_W-1:0] load,
	output logic [DATA_W-1:0] data_q
);

	// The held value moves with the chain; contents start undefined.
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LEFT:  data_q <= left;
			OP_RIGHT: data_q <= right;
			OP_LOAD:  data_q <= load;
			OP_WRAP:  data_q <= wrap;
			default:  data_q <= data_q;
		endcase
	end

endmodule

[sv/positional_list_engine.sv]
// Top level of the positional list engine: controller and chain of cells.
//
// The list lives in a row of DEPTH cells, head in cell 0. A valid insert or delete
// shifts every cell behind the position by one place in the cycle the request
// is accepted, so its single result appears on the next cycle; the input stalls
// until that result has been taken. A dump rotates the chain by one cell per
// delivered result, and leaves the list in its original order. No clearing pass
// is needed after reset: only cells below the fill count are ever shown.
module positional_list_engine
	import plc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] value,
	input  logic [POS_W-1:0]         position,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ST_W-1:0]          status,
	output logic signed [DATA_W-1:0] element,
	output logic [CNT_W-1:0]         element_count,
	output logic                     last
);

	localparam int FW = $clog2(DEPTH + 1);

	state_t            state_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     dcnt_q;
	logic [ST_W-1:0]   status_q;
	logic [DATA_W-1:0] cell_q [DEPTH];
	cell_ctl_t         ctl [DEPTH];

	logic              in_acc;
	logic              out_acc;
	logic [CMP_W-1:0]  pos9;
	logic [CMP_W-1:0]  fill9;
	logic [CMP_W-1:0]  p9;
	logic              ins_ok;
	logic              ins_full;
	logic              del_ok;
	logic              dump_last;
	logic [FW+CNT_W-1:0] fill_ext;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Position checks against the current fill.
	assign pos9     = {1'b0, position};
	assign fill9    = CMP_W'(fill_q);
	assign p9       = pos9 - CMP_W'(1);
	assign ins_ok   = (position != '0) && (pos9 <= fill9 + CMP_W'(1));
	assign ins_full = fill9 >= CMP_W'(DEPTH);
	assign del_ok   = (position != '0) && (pos9 <= fill9);
	assign dump_last = (dcnt_q == fill_q - FW'(1));

	// Per-cell shift control.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_lastc
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_q[i+1];
		end

		always_comb begin
			ctl[i].op = OP_HOLD;
			case (state_q)
				S_IDLE: begin
					if (in_acc && command == CMD_INSERT && ins_ok && !ins_full) begin
						if (IDX > p9)
							ctl[i].op = OP_LEFT;
						else if (IDX == p9)
							ctl[i].op = OP_LOAD;
					end else if (in_acc && command == CMD_DELETE && del_ok) begin
						if (IDX >= p9)
							ctl[i].op = OP_RIGHT;
					end
				end
				S_DUMP: begin
					if (out_acc) begin
						if (IDX + CMP_W'(1) < fill9)
							ctl[i].op = OP_RIGHT;
						else if (IDX + CMP_W'(1) == fill9)
							ctl[i].op = OP_WRAP;
					end
				end
				default: ctl[i].op = OP_HOLD;
			endcase
		end

		plc_cell u_cell (
			.clk    (clk),
			.ctl    (ctl[i]),
			.left   (left_d),
			.right  (right_d),
			.wrap   (cell_q[0]),
			.load   (value),
			.data_q (cell_q[i])
		);
	end

	// Request sequencing, fill count and status register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			dcnt_q   <= '0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_RESP;
						dcnt_q  <= '0;
						case (command)
							CMD_INSERT: begin
								if (!ins_ok) begin
									status_q <= ST_INVALID;
								end else if (ins_full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									fill_q   <= fill_q + FW'(1);
								end
							end
							CMD_DELETE: begin
								if (!del_ok) begin
									status_q <= ST_INVALID;
								end else begin
									status_q <= ST_OK;
									fill_q   <= fill_q - FW'(1);
								end
							end
							CMD_DUMP: begin
								if (fill_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_DUMP;
								end
							end
							default: status_q <= ST_INVALID;
						endcase
					end
				end
				S_RESP: begin
					if (out_acc)
						state_q <= S_IDLE;
				end
				S_DUMP: begin
					if (out_acc) begin
						dcnt_q <= dcnt_q + FW'(1);
						if (dump_last)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result fields; a dump shows the head cell as the chain rotates.
	assign fill_ext      = {{CNT_W{1'b0}}, fill_q};
	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = (state_q == S_RESP) || (state_q == S_DUMP);
	assign status        = (state_q == S_DUMP) ? ST_OK : status_q;
	assign element       = (state_q == S_DUMP) ? cell_q[0] : '0;
	assign element_count = fill_ext[CNT_W-1:0];
	assign last          = (state_q == S_DUMP) ? dump_last : 1'b1;

endmodule

[sv/plc_checker.sv]
// Port-level checks for the positional list engine, bound to the top level.
module plc_checker
	import plc_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [ST_W-1:0]          status,
	input logic signed [DATA_W-1:0] element,
	input logic [CNT_W-1:0]         element_count,
	input logic                     last
);

	// A stalled result holds its fields.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(element)
			&& $stable(element_count) && $stable(last))
		else $error("stalled result changed");

	// An accepted request always produces a result on the next cycle.
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid && in_stall)
		else $error("request accepted without a following result");

	// An empty-list result comes with no elements and ends the request.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> element_count == '0 && last)
		else $error("empty status with elements held");

	// Any result that is not ok is a single result with no element.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> element == '0 && last)
		else $error("error result carries an element or is not last");

	// A request is never accepted while results are still outstanding.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while results outstanding");

endmodule

bind positional_list_engine plc_checker u_plc_checker (.*);

[sim/plc_list_checker.sv]
// Checker for the positional list engine: predicts every result and compares it.
module plc_list_checker
	import plc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] value,
	input  logic [POS_W-1:0]         position,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [ST_W-1:0]          status,
	input  logic signed [DATA_W-1:0] element,
	input  logic [CNT_W-1:0]         element_count,
	input  logic                     last,
	output int                       fail_count,
	output int                       pending,
	output int                       held
);

	typedef struct {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] element;
		logic [CNT_W-1:0]         count;
		logic                     last;
	} list_result_t;

	// Shadow copy of the list, head first, and the results still owed by the block.
	logic signed [DATA_W-1:0] list_q[$];
	list_result_t             due_q[$];

	initial begin
		fail_count = 0;
		pending    = 0;
		held       = 0;
	end

	// A result carries the count as it stands once the request has been applied.
	function automatic list_result_t make_result(input logic [ST_W-1:0] st,
			input logic signed [DATA_W-1:0] elem, input logic fin);
		list_result_t r;
		r.status  = st;
		r.element = elem;
		r.count   = CNT_W'(list_q.size());
		r.last    = fin;
		return r;
	endfunction

	// Apply one accepted request to the shadow list and queue what it should produce.
	task automatic apply_request(input logic [CMD_W-1:0] cmd,
			input logic signed [DATA_W-1:0] val, input logic [POS_W-1:0] pos);
		int n;
		n = list_q.size();
		case (cmd)
			CMD_INSERT: begin
				if (pos == 0 || int'(pos) > n + 1) begin
					due_q.push_back(make_result(ST_INVALID, '0, 1'b1));
				end else if (n >= DEPTH) begin
					due_q.push_back(make_result(ST_FULL, '0, 1'b1));
				end else begin
					list_q.insert(int'(pos) - 1, val);
					due_q.push_back(make_result(ST_OK, '0, 1'b1));
				end
			end
			CMD_DELETE: begin
				if (pos == 0 || int'(pos) > n) begin
					due_q.push_back(make_result(ST_INVALID, '0, 1'b1));
				end else begin
					list_q.delete(int'(pos) - 1);
					due_q.push_back(make_result(ST_OK, '0, 1'b1));
				end
			end
			CMD_DUMP: begin
				if (n == 0) begin
					due_q.push_back(make_result(ST_EMPTY, '0, 1'b1));
				end else begin
					for (int i = 0; i < n; i++)
						due_q.push_back(make_result(ST_OK, list_q[i], i == n - 1));
				end
			end
			default: begin
				// The spare command code is refused without touching the list.
				due_q.push_back(make_result(ST_INVALID, '0, 1'b1));
			end
		endcase
	endtask

	// Results are checked before the request of the same edge is applied, since a
	// result can never stem from a request accepted at the very same edge.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_q.size() == 0) begin
					$display("%0t: unexpected result: status %0d element %0d count %0d last %0d",
						$time, status, element, element_count, last);
					fail_count++;
				end else begin
					want = due_q.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $time, want.status, status);
						fail_count++;
					end
					if (element !== want.element) begin
						$display("%0t: element expected %0d, got %0d", $time, want.element,
							element);
						fail_count++;
					end
					if (element_count !== want.count) begin
						$display("%0t: element_count expected %0d, got %0d", $time, want.count,
							element_count);
						fail_count++;
					end
					if (last !== want.last) begin
						$display("%0t: last expected %0d, got %0d", $time, want.last, last);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				apply_request(command, value, position);
			pending = due_q.size();
			held    = list_q.size();
		end
	end

endmodule

[sim/tb.sv]
// Testbench top for the positional list engine: clock, reset, requests and verdict.
module tb;
	import plc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 280;
	localparam int HOLD_AT      = 230;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [CMD_W-1:0]         command = CMD_INSERT;
	logic signed [DATA_W-1:0] value = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] element;
	logic [CNT_W-1:0]         element_count;
	logic                     last;

	int fail_count;
	int pending;
	int held;
	int cycles = 0;
	int items_sent = 0;
	int tx_idle_pct = 19;
	int rx_idle_pct = 66;
	int hold_left = 0;
	bit hold_done = 1'b0;

	positional_list_engine u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.element      (element),
		.element_count(element_count),
		.last         (last)
	);

	plc_list_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.element      (element),
		.element_count(element_count),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending),
		.held         (held)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Give up on a hung block.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off so that the block backs up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
		end else if (!hold_done && items_sent >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Offer one request, with random gaps ahead of it, and wait until it is taken.
	task automatic issue(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= val;
		position <= pos;
		do @(posedge clk); while (in_stall);
		items_sent <= items_sent + 1;
		@(negedge clk);
	endtask

	// A random request, biased towards growing or shrinking the list, with most
	// positions inside the range the current length allows.
	task automatic random_request(input bit grow);
		int r;
		int lim;
		int pos;
		logic [CMD_W-1:0] cmd;
		logic signed [DATA_W-1:0] val;
		r = $urandom_range(0, 99);
		if (r < 15)
			cmd = CMD_DUMP;
		else if (r < 20)
			cmd = CMD_UNUSED;
		else if (r < 80)
			cmd = grow ? CMD_INSERT : CMD_DELETE;
		else
			cmd = grow ? CMD_DELETE : CMD_INSERT;
		val = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = '0;
				default: val = '1;
			endcase
		end
		lim = (cmd == CMD_INSERT) ? held + 1 : held;
		r = $urandom_range(0, 99);
		if ((cmd == CMD_INSERT || cmd == CMD_DELETE) && r < 75 && lim > 0)
			pos = $urandom_range(1, lim);
		else if (r < 88)
			pos = $urandom_range(0, 1) ? 0 : $urandom_range(lim + 1, DEPTH_DEF + 2);
		else
			pos = $urandom_range(0, 255);
		issue(cmd, val, POS_W'(pos));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed start: refusals on an empty list, value extremes, head and tail.
		issue(CMD_DUMP,   '0, 8'd0);
		issue(CMD_DELETE, '0, 8'd1);
		issue(CMD_INSERT, 32'sd5, 8'd0);
		issue(CMD_INSERT, 32'sd6, 8'd2);
		issue(CMD_UNUSED, 32'sd7, 8'd1);
		issue(CMD_INSERT, 32'h8000_0000, 8'd1);
		issue(CMD_INSERT, 32'h7fff_ffff, 8'd2);
		issue(CMD_INSERT, -32'sd1, 8'd1);
		issue(CMD_INSERT, '0, 8'd4);
		issue(CMD_INSERT, 32'sd9, 8'd255);
		issue(CMD_DELETE, '0, 8'd5);
		issue(CMD_DUMP,   '0, 8'd255);
		issue(CMD_DELETE, '0, 8'd4);
		issue(CMD_DELETE, '0, 8'd1);
		issue(CMD_DELETE, '0, 8'd0);
		issue(CMD_DUMP,   '0, 8'd0);

		// Random part in three idling phases; the list alternately grows and shrinks.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 3) begin
				tx_idle_pct <= 66;
				rx_idle_pct <= 19;
			end else if (k == 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
			end
			random_request((k / 45) % 2 == 0);
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
sv/plc_pkg.sv
sv/plc_cell.sv
sv/positional_list_engine.sv
sv/plc_checker.sv
sim/plc_list_checker.sv
sim/tb.sv
